// ===== rtl/core/mt19937_random_generator_assert.svh =====
// ----------------------------------------------------------------------------
// MT19937 random generator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MT19937_RANDOM_GENERATOR_ASSERT_SVH
`define MT19937_RANDOM_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define MTRG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MTRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mtrg_pkg.sv =====
// ----------------------------------------------------------------------------
// MT19937 generator package
// Word type, request codes and the fixed constants of the generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtrg_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned SHIFT_OFFSET = 397;
  localparam int unsigned SEED_CNT_W   = $clog2(STATE_WORDS);

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [SEED_CNT_W-1:0] seed_cnt_t;

  typedef enum logic [0:0] {
    REQ_DRAW   = 1'b0,
    REQ_RESEED = 1'b1
  } req_kind_e;

  localparam word_t INIT_MULT    = 32'd1812433253;
  localparam word_t TWIST_MATRIX = 32'h9908_b0df;
  localparam word_t HIGH_BIT     = 32'h8000_0000;
  localparam word_t LOW_BITS     = 32'h7fff_ffff;
  localparam word_t TEMPER_B     = 32'h9d2c_5680;
  localparam word_t TEMPER_C     = 32'hefc6_0000;
  localparam word_t DEFAULT_SEED = 32'd5489;

  localparam seed_cnt_t SEED_LAST = seed_cnt_t'(STATE_WORDS - 1);

endpackage

// ===== rtl/core/mtrg_if.sv =====
// ----------------------------------------------------------------------------
// MT19937 generator channels
// Valid/ready request and response channels of the generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtrg_req_if import mtrg_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  req_type;
  word_t seed;

  modport source (output valid, output req_type, output seed, input ready);
  modport sink   (input valid, input req_type, input seed, output ready);
endinterface

interface mtrg_rsp_if import mtrg_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// ===== rtl/core/mtrg_cell.sv =====
// ----------------------------------------------------------------------------
// MT19937 store cell
// One word of the state store; loads word_i (its neighbour's word, or the new word at the tail) when shifted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtrg_cell import mtrg_pkg::*; (
  input  logic  clk_i,
  input  logic  shift_i,
  input  word_t word_i,
  output word_t word_o
);

  word_t word_q;
  word_t word_d;

  assign word_d = shift_i ? word_i : word_q;

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== rtl/core/mtrg_twist.sv =====
// ----------------------------------------------------------------------------
// MT19937 twist and temper
// Forms the next store word from the head, its neighbour and the far tap,
// and the tempered output word derived from it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtrg_twist import mtrg_pkg::*; (
  input  word_t head_i,
  input  word_t next_i,
  input  word_t far_i,
  output word_t word_o,
  output word_t tempered_o
);

  word_t mix;
  word_t twisted;
  word_t t1;
  word_t t2;
  word_t t3;

  assign mix     = (head_i & HIGH_BIT) | (next_i & LOW_BITS);
  assign twisted = far_i ^ (mix >> 1) ^ (mix[0] ? TWIST_MATRIX : '0);

  assign t1 = twisted ^ (twisted >> 11);
  assign t2 = t1 ^ ((t1 << 7) & TEMPER_B);
  assign t3 = t2 ^ ((t2 << 15) & TEMPER_C);

  assign word_o     = twisted;
  assign tempered_o = t3 ^ (t3 >> 18);

endmodule

// ===== rtl/core/mt19937_random_generator.sv =====
// ----------------------------------------------------------------------------
// MT19937 random generator
// The state lives in a 624-stage shift line of word cells. A draw twists the
// word at the head, pushes the result onto the tail and returns it tempered,
// so draws sustain one word per clock while the response side keeps up. A
// reseed runs the seed recurrence through a single multiplier, one word per
// cycle, and holds the request side off until the store is filled; the same
// fill with seed 5489 follows reset before the first request is taken. A
// reseed gives no response beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mt19937_random_generator import mtrg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtrg_req_if.sink    req_i,
  mtrg_rsp_if.source  rsp_o
);

  `include "mt19937_random_generator_assert.svh"

  logic      seed_busy_q;
  seed_cnt_t seed_cnt_q;
  word_t     seed_q;
  logic      rsp_valid_q;
  word_t     rsp_word_q;

  logic  req_acc;
  logic  draw_acc;
  logic  reseed_acc;
  logic  shift;
  word_t tail_d;
  word_t seed_mix;
  word_t seed_prod;
  word_t seed_word;
  word_t twist_word;
  word_t tempered;

  word_t chain_w [STATE_WORDS];

  assign req_acc    = req_i.valid && req_i.ready;
  assign draw_acc   = req_acc && (req_i.req_type == REQ_DRAW);
  assign reseed_acc = req_acc && (req_i.req_type == REQ_RESEED);

  assign req_i.ready = !seed_busy_q && (!rsp_valid_q || rsp_o.ready);

  // seed recurrence runs off the word last pushed onto the tail
  assign seed_mix  = chain_w[STATE_WORDS-1] ^ (chain_w[STATE_WORDS-1] >> 30);
  assign seed_prod = INIT_MULT * seed_mix;
  assign seed_word = (seed_cnt_q == '0) ? seed_q
                                        : seed_prod + word_t'(seed_cnt_q);

  assign shift  = seed_busy_q || draw_acc;
  assign tail_d = seed_busy_q ? seed_word : twist_word;

  for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
    if (i == STATE_WORDS - 1) begin : g_tail
      mtrg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .word_i  (tail_d),
        .word_o  (chain_w[i])
      );
    end else begin : g_body
      mtrg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .word_i  (chain_w[i+1]),
        .word_o  (chain_w[i])
      );
    end
  end

  mtrg_twist u_twist (
    .head_i     (chain_w[0]),
    .next_i     (chain_w[1]),
    .far_i      (chain_w[SHIFT_OFFSET]),
    .word_o     (twist_word),
    .tempered_o (tempered)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_busy_q <= 1'b1;
      seed_cnt_q  <= '0;
      seed_q      <= DEFAULT_SEED;
    end else if (seed_busy_q) begin
      if (seed_cnt_q == SEED_LAST) begin
        seed_busy_q <= 1'b0;
      end
      seed_cnt_q <= seed_cnt_q + 1'b1;
    end else if (reseed_acc) begin
      seed_busy_q <= 1'b1;
      seed_cnt_q  <= '0;
      seed_q      <= req_i.seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (draw_acc) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_acc) begin
      rsp_word_q <= tempered;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.random_word = rsp_word_q;

  `MTRG_ASSERT_NOW(a_no_req_while_seeding, seed_busy_q, !req_i.ready,
    "request taken during seed fill")
  `MTRG_ASSERT_NOW(a_seed_cnt_range, seed_busy_q, seed_cnt_q <= SEED_LAST,
    "seed counter past end of store")
  `MTRG_ASSERT_NEXT(a_draw_gives_beat, draw_acc, rsp_o.valid,
    "draw did not produce a response beat")
  `MTRG_ASSERT_NEXT(a_reseed_starts_fill, reseed_acc, seed_busy_q && seed_cnt_q == '0,
    "reseed did not start a seed fill")

endmodule

// ===== tb/mt19937_draw_checker.sv =====
// ----------------------------------------------------------------------------
// MT19937 draw checker
// Watches the request and response channels of the generator. It keeps its
// own copy of the 624-word state, replays every accepted reseed and draw on
// it, and compares each response beat with the oldest predicted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mt19937_draw_checker import mtrg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mtrg_req_if  req_i,
  mtrg_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   checked_o,
  output int   outstanding_o
);

  word_t       mt_words [STATE_WORDS];
  int unsigned mt_pos;
  word_t       expected_words [$];
  word_t       want_word;
  int          fails;
  int          checked;

  task automatic load_seed(input word_t s);
    word_t p;
    mt_words[0] = s;
    for (int i = 1; i < STATE_WORDS; i++) begin
      p = mt_words[i-1];
      mt_words[i] = INIT_MULT * (p ^ (p >> 30)) + word_t'(i);
    end
    mt_pos = STATE_WORDS;
  endtask

  task automatic regenerate_words();
    word_t y;
    word_t v;
    int    nxt;
    int    far;
    for (int k = 0; k < STATE_WORDS; k++) begin
      nxt = (k + 1) % STATE_WORDS;
      far = (k + SHIFT_OFFSET) % STATE_WORDS;
      y = (mt_words[k] & HIGH_BIT) | (mt_words[nxt] & LOW_BITS);
      v = mt_words[far] ^ (y >> 1);
      if (y[0]) v = v ^ TWIST_MATRIX;
      mt_words[k] = v;
    end
    mt_pos = 0;
  endtask

  function automatic word_t temper_word(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  task automatic predict_draw(output word_t w);
    if (mt_pos >= STATE_WORDS) regenerate_words();
    w = temper_word(mt_words[mt_pos]);
    mt_pos++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_seed(DEFAULT_SEED);
      expected_words.delete();
      fails   = 0;
      checked = 0;
    end else begin
      // request first; a same-cycle response beat still pops the oldest word,
      // which always belongs to an earlier draw
      if (req_i.valid && req_i.ready) begin
        if (req_kind_e'(req_i.req_type) == REQ_RESEED) begin
          load_seed(req_i.seed);
        end else begin
          predict_draw(want_word);
          expected_words.push_back(want_word);
        end
      end
      if (rsp_i.valid && rsp_i.ready) begin
        checked++;
        if (expected_words.size() == 0) begin
          fails++;
          $display("%0t: response beat with none expected, expected none, got %08h",
                   $time, rsp_i.random_word);
        end else begin
          want_word = expected_words.pop_front();
          if (rsp_i.random_word !== want_word) begin
            fails++;
            $display("%0t: random_word wrong, expected %08h, got %08h",
                     $time, want_word, rsp_i.random_word);
          end
        end
      end
    end
    fail_count_o  <= fails;
    checked_o     <= checked;
    outstanding_o <= expected_words.size();
  end

endmodule

// ===== tb/tb_mt19937_random_generator.sv =====
// ----------------------------------------------------------------------------
// MT19937 random generator testbench
// Directed draws and reseeds at the seed extremes, then a long random stream
// of draws crossing several regenerations with scattered reseeds. Both sides
// stall at random; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mt19937_random_generator import mtrg_pkg::*;;

  localparam int RANDOM_ITEMS   = 2000;
  localparam int LONG_RUN       = 700;   // draws in a row to cross a regeneration
  localparam int MAX_IDLE       = 16;
  localparam int SETTLE_CYCLES  = 640;   // covers a trailing reseed fill
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni;

  mtrg_req_if req_ch ();
  mtrg_rsp_if rsp_ch ();

  int fail_count;
  int checked;
  int outstanding;
  int draws_sent;
  int reseeds_sent;
  int idle_cycles;
  bit req_fast;
  bit rsp_fast;

  mt19937_random_generator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  mt19937_draw_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_ch),
    .rsp_i         (rsp_ch),
    .fail_count_o  (fail_count),
    .checked_o     (checked),
    .outstanding_o (outstanding)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_req(input req_kind_e kind, input word_t s);
    int gap;
    gap = req_fast ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.seed     <= s;
    do @(posedge clk_i); while (!(req_ch.valid && req_ch.ready));
    if (kind == REQ_RESEED) reseeds_sent++;
    else draws_sent++;
  endtask

  function automatic word_t pick_seed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return DEFAULT_SEED;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_DRAW;
    req_ch.seed     <= '0;
    rst_ni          <= 1'b0;
    req_fast        = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default stream, first draw regenerates
    repeat (3) send_req(REQ_DRAW, $urandom);
    // seed zero is taken as is
    send_req(REQ_RESEED, '0);
    repeat (2) send_req(REQ_DRAW, $urandom);
    send_req(REQ_RESEED, '1);
    send_req(REQ_DRAW, '1);
    // back to the default seed: stream restarts
    send_req(REQ_RESEED, DEFAULT_SEED);
    send_req(REQ_DRAW, '0);
    // back-to-back reseeds, only the last counts
    send_req(REQ_RESEED, 32'h0000_0001);
    send_req(REQ_RESEED, 32'h8000_0000);
    send_req(REQ_DRAW, '0);
    send_req(REQ_RESEED, 32'haaaa_aaaa);
    send_req(REQ_DRAW, '1);
    send_req(REQ_DRAW, '0);
    send_req(REQ_RESEED, 32'h5555_5555);
    send_req(REQ_DRAW, 32'h5555_5555);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) req_fast = ($urandom_range(0, 3) == 0);
      if (n >= LONG_RUN && $urandom_range(0, 29) == 0) send_req(REQ_RESEED, pick_seed());
      else send_req(REQ_DRAW, $urandom);
    end
    req_ch.valid <= 1'b0;

    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Requests: %0d draws, %0d reseeds; %0d response words compared.",
             draws_sent, reseeds_sent, checked);
    $display("Streams crossed regenerations with random stalls on both channels.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int stall;
    int beats;
    rsp_ch.ready <= 1'b0;
    rsp_fast = 1'b0;
    beats    = 0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      if (beats % 50 == 0) rsp_fast = ($urandom_range(0, 3) == 0);
      stall = rsp_fast ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_ch.valid && rsp_ch.ready));
      beats++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles at %0t", WATCHDOG_LIMIT, $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule
